@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/vsar_pkg.sv @@
// Package for the video scroll address registers block: request codes,
// address masks, timing limits and the structs passed between modules.
// Depends on nothing.
`default_nettype none

package vsar_pkg;

   localparam int unsigned LAST_DOT           = 340;
   localparam int unsigned LAST_LINE          = 261;
   localparam int unsigned SPRITE_TABLE_DEPTH = 256;

   localparam logic [3:0] REQ_TICK     = 4'd0;
   localparam logic [3:0] REQ_CTRL_WR  = 4'd1;
   localparam logic [3:0] REQ_MASK_WR  = 4'd2;
   localparam logic [3:0] REQ_STAT_RD  = 4'd3;
   localparam logic [3:0] REQ_OAMA_WR  = 4'd4;
   localparam logic [3:0] REQ_OAMD_WR  = 4'd5;
   localparam logic [3:0] REQ_OAMD_RD  = 4'd6;
   localparam logic [3:0] REQ_SCROL_WR = 4'd7;
   localparam logic [3:0] REQ_ADDR_WR  = 4'd8;
   localparam logic [3:0] REQ_DATA_WR  = 4'd9;
   localparam logic [3:0] REQ_DATA_RD  = 4'd10;

   localparam logic [15:0] HORIZ_MASK     = 16'h041F;
   localparam logic [15:0] SCROLL_KEEP    = 16'h8C1F;
   localparam logic [15:0] CTRL_NT_KEEP   = 16'hF3FF;
   localparam logic [15:0] NT_H_BIT       = 16'h0400;
   localparam logic [15:0] NT_V_BIT       = 16'h0800;
   localparam logic [15:0] FINE_Y_ONE     = 16'h1000;
   localparam logic [8:0]  VBLANK_LINE    = 9'd241;
   localparam logic [8:0]  POST_LINE      = 9'd240;
   localparam logic [4:0]  COARSE_Y_WRAP  = 5'd29;
   localparam logic [4:0]  COARSE_Y_LAST  = 5'd31;

   typedef struct packed {
      logic [7:0]  read_byte;
      logic        nmi_out;
      logic [15:0] vmem_address;
      logic        vmem_read;
      logic        vmem_write;
      logic [8:0]  dot_now;
      logic [8:0]  line_now;
   } rsp_type;

   typedef struct packed {
      logic       wr;
      logic [7:0] ptr;
      logic [7:0] data;
   } oam_access_type;

endpackage

`default_nettype wire

@@ rtl/vsar_oam.sv @@
// Sprite attribute memory with per-entry valid bits; unwritten entries read 0.
// Read data is registered on each advance. Depends on vsar_pkg.
`default_nettype none

module vsar_oam
   import vsar_pkg::*;
#(
   parameter int unsigned DEPTH = SPRITE_TABLE_DEPTH
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           advance,
   input  wire oam_access_type oam_acc,
   output logic [7:0]          rd_data
);

   localparam int unsigned AW = $clog2(DEPTH);

   logic [7:0]       mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [7:0]       rdata_ff;
   logic             hit_ff;
   logic [AW-1:0]    idx;

   assign idx = oam_acc.ptr[AW-1:0];

   always_ff @(posedge clock) begin
      if (advance && oam_acc.wr) begin
         mem[idx] <= oam_acc.data;
      end
      if (advance) begin
         rdata_ff <= mem[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else if (advance) begin
         hit_ff <= valid_ff[idx];
         if (oam_acc.wr) begin
            valid_ff[idx] <= 1'b1;
         end
      end
   end

   assign rd_data = hit_ff ? rdata_ff : 8'd0;

endmodule

`default_nettype wire

@@ rtl/vsar_core.sv @@
// Register state and next-state logic: dot/line timing, vblank, scroll
// addresses, write latch and bus strobes. Depends on vsar_pkg.
`default_nettype none

module vsar_core
   import vsar_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic [3:0] req_type,
   input  wire logic [7:0] data_byte,
   input  wire logic       peek,
   output rsp_type         rsp_in,
   output logic            oam_sel_in,
   output oam_access_type  oam_acc
);

   localparam logic [8:0] DOT_MAX   = 9'(LAST_DOT);
   localparam logic [8:0] LINE_MAX  = 9'(LAST_LINE);
   localparam logic [8:0] DOT_Y_INC = 9'd256;
   localparam logic [8:0] DOT_H_CPY = 9'd257;
   localparam logic [8:0] DOT_FETCH = 9'd320;
   localparam logic [8:0] DOT_V_LO  = 9'd280;
   localparam logic [8:0] DOT_V_HI  = 9'd304;

   logic [8:0]  dot_ff, dot_in, line_ff, line_in, dot_adv, line_adv;
   logic [15:0] v_ff, v_in, t_ff, t_in, v_tmp, step;
   logic [2:0]  fx_ff, fx_in;
   logic        w_ff, w_in, vbl_ff, vbl_in;
   logic [7:0]  ctrl_ff, ctrl_in, mask_ff, mask_in, ptr_ff, ptr_in;
   logic        x_go;

   function automatic logic [15:0] x_step(input logic [15:0] v);
      logic [15:0] r;
      if (v[4:0] == 5'd31) begin
         r = {v[15:5], 5'd0} ^ NT_H_BIT;
      end else begin
         r = v + 16'd1;
      end
      return r;
   endfunction

   function automatic logic [15:0] y_step(input logic [15:0] v);
      logic [15:0] r;
      logic [4:0]  cy;
      r  = v;
      cy = v[9:5];
      if (v[14:12] != 3'd7) begin
         r = v + FINE_Y_ONE;
      end else begin
         r[14:12] = 3'd0;
         if (cy == COARSE_Y_WRAP) begin
            r[9:5] = 5'd0;
            r      = r ^ NT_V_BIT;
         end else if (cy == COARSE_Y_LAST) begin
            r[9:5] = 5'd0;
         end else begin
            r[9:5] = cy + 5'd1;
         end
      end
      return r;
   endfunction

   always_comb begin
      dot_adv  = (dot_ff == DOT_MAX) ? 9'd0 : dot_ff + 9'd1;
      line_adv = line_ff;
      if (dot_ff == DOT_MAX) begin
         line_adv = (line_ff == LINE_MAX) ? 9'd0 : line_ff + 9'd1;
      end
      x_go = ((dot_ff < DOT_Y_INC) || (dot_ff > DOT_FETCH)) && (dot_ff[2:0] == 3'd0);
      v_tmp = x_go ? x_step(v_ff) : v_ff;
      step  = ctrl_ff[2] ? 16'd32 : 16'd1;
   end

   always_comb begin
      dot_in  = dot_ff;
      line_in = line_ff;
      v_in    = v_ff;
      t_in    = t_ff;
      fx_in   = fx_ff;
      w_in    = w_ff;
      vbl_in  = vbl_ff;
      ctrl_in = ctrl_ff;
      mask_in = mask_ff;
      ptr_in  = ptr_ff;
      rsp_in  = '0;
      oam_sel_in   = 1'b0;
      oam_acc.wr   = 1'b0;
      oam_acc.ptr  = ptr_ff;
      oam_acc.data = data_byte;

      case (req_type)
         REQ_TICK: begin
            dot_in  = dot_adv;
            line_in = line_adv;
            if (dot_ff != 9'd0) begin
               if ((line_ff >= POST_LINE) && (line_ff < LINE_MAX)) begin
                  if ((dot_ff == 9'd1) && (line_ff == VBLANK_LINE)) begin
                     vbl_in = 1'b1;
                  end
               end else begin
                  if ((dot_ff == 9'd1) && (line_ff == LINE_MAX)) begin
                     vbl_in = 1'b0;
                  end
                  if (mask_ff[3]) begin
                     if (dot_ff == DOT_Y_INC) begin
                        v_in = y_step(v_tmp);
                     end else if (dot_ff == DOT_H_CPY) begin
                        v_in = (v_tmp & ~HORIZ_MASK) | (t_ff & HORIZ_MASK);
                     end else if ((line_ff == LINE_MAX) && (dot_ff >= DOT_V_LO)
                                  && (dot_ff <= DOT_V_HI)) begin
                        v_in = (v_tmp & HORIZ_MASK) | (t_ff & ~HORIZ_MASK);
                     end else begin
                        v_in = v_tmp;
                     end
                  end
               end
            end
         end
         REQ_CTRL_WR: begin
            ctrl_in = data_byte;
            t_in    = (t_ff & CTRL_NT_KEEP) | {4'd0, data_byte[1:0], 10'd0};
         end
         REQ_MASK_WR: begin
            mask_in = data_byte;
         end
         REQ_STAT_RD: begin
            rsp_in.read_byte = {vbl_ff, 7'd0};
            if (!peek) begin
               vbl_in = 1'b0;
               w_in   = 1'b0;
            end
         end
         REQ_OAMA_WR: begin
            ptr_in = data_byte;
         end
         REQ_OAMD_WR: begin
            oam_acc.wr = 1'b1;
            ptr_in     = ptr_ff + 8'd1;
         end
         REQ_OAMD_RD: begin
            oam_sel_in = 1'b1;
         end
         REQ_SCROL_WR: begin
            if (!w_ff) begin
               t_in  = {t_ff[15:5], data_byte[7:3]};
               fx_in = data_byte[2:0];
            end else begin
               t_in = (t_ff & SCROLL_KEEP) | {1'b0, data_byte[2:0], 2'd0,
                                               data_byte[7:3], 5'd0};
            end
            w_in = ~w_ff;
         end
         REQ_ADDR_WR: begin
            if (!w_ff) begin
               t_in = {2'd0, data_byte[5:0], t_ff[7:0]};
            end else begin
               t_in = {t_ff[15:8], data_byte};
               v_in = {t_ff[15:8], data_byte};
            end
            w_in = ~w_ff;
         end
         REQ_DATA_WR: begin
            rsp_in.vmem_address = v_ff;
            rsp_in.vmem_write   = 1'b1;
            v_in                = v_ff + step;
         end
         REQ_DATA_RD: begin
            rsp_in.vmem_address = v_ff;
            rsp_in.vmem_read    = 1'b1;
            if (!peek) begin
               v_in = v_ff + step;
            end
         end
         default: begin
         end
      endcase

      rsp_in.nmi_out  = ctrl_in[7] & vbl_in;
      rsp_in.dot_now  = dot_in;
      rsp_in.line_now = line_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff  <= '0;
         line_ff <= '0;
         v_ff    <= '0;
         t_ff    <= '0;
         fx_ff   <= '0;
         w_ff    <= 1'b0;
         vbl_ff  <= 1'b0;
         ctrl_ff <= '0;
         mask_ff <= '0;
         ptr_ff  <= '0;
      end else if (advance) begin
         dot_ff  <= dot_in;
         line_ff <= line_in;
         v_ff    <= v_in;
         t_ff    <= t_in;
         fx_ff   <= fx_in;
         w_ff    <= w_in;
         vbl_ff  <= vbl_in;
         ctrl_ff <= ctrl_in;
         mask_ff <= mask_in;
         ptr_ff  <= ptr_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/video_scroll_address_registers.sv @@
// Video scroll address registers: picture-unit timing and CPU register core.
// Instantiates vsar_core and vsar_oam; depends on vsar_pkg.
//
// Input channel (req_valid/req_ready): one transaction per dot tick or CPU
// register access, coded by req_type, with req_data_byte and req_peek.
// Result channel (rsp_valid/rsp_ready): exactly one result per request, in
// order: read byte, interrupt line, video memory address and strobes, and
// the dot and line counters after the request.
// Order: a request taken sits in the input register, moves to the result
// register when the core advances, and is then offered to the receiver.
// One request per cycle is sustained while the receiver does not stall;
// the state update and sprite memory read happen in the same cycle.
// When the receiver stalls, the result register holds and the input
// register still takes one more request; req_ready drops once both are full.
// Reset (synchronous, active high) clears counters, addresses, latch,
// flags, control and mask bytes, the sprite pointer, and all sprite memory
// valid bits, so the memory reads as zero until written.
// Requests are taken from the first cycle after reset.
`default_nettype none

module video_scroll_address_registers
   import vsar_pkg::*;
#(
   parameter int unsigned SPRITE_DEPTH = SPRITE_TABLE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [3:0]  req_type,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_peek,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_read_byte,
   output logic             rsp_nmi_out,
   output logic [15:0]      rsp_vmem_address,
   output logic             rsp_vmem_read,
   output logic             rsp_vmem_write,
   output logic [8:0]       rsp_dot_now,
   output logic [8:0]       rsp_line_now
);

   logic           s1_valid_ff, rsp_valid_ff, advance;
   logic [3:0]     type_ff;
   logic [7:0]     data_ff;
   logic           peek_ff;
   rsp_type        rsp_in, rsp_ff;
   logic           oam_sel_in, oam_sel_ff;
   oam_access_type oam_acc;
   logic [7:0]     oam_data;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         type_ff <= req_type;
         data_ff <= req_data_byte;
         peek_ff <= req_peek;
      end
      if (advance) begin
         rsp_ff     <= rsp_in;
         oam_sel_ff <= oam_sel_in;
      end
   end

   vsar_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .req_type   (type_ff),
      .data_byte  (data_ff),
      .peek       (peek_ff),
      .rsp_in     (rsp_in),
      .oam_sel_in (oam_sel_in),
      .oam_acc    (oam_acc)
   );

   vsar_oam #(
      .DEPTH (SPRITE_DEPTH)
   ) u_oam (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .oam_acc (oam_acc),
      .rd_data (oam_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_byte    = oam_sel_ff ? oam_data : rsp_ff.read_byte;
   assign rsp_nmi_out      = rsp_ff.nmi_out;
   assign rsp_vmem_address = rsp_ff.vmem_address;
   assign rsp_vmem_read    = rsp_ff.vmem_read;
   assign rsp_vmem_write   = rsp_ff.vmem_write;
   assign rsp_dot_now      = rsp_ff.dot_now;
   assign rsp_line_now     = rsp_ff.line_now;

endmodule

`default_nettype wire

@@ rtl/vsar_checker.sv @@
// Port-level checker for video_scroll_address_registers, bound to the top.
// Depends on vsar_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module vsar_checker
   import vsar_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_read_byte,
   input wire logic [15:0] rsp_vmem_address,
   input wire logic        rsp_vmem_read,
   input wire logic        rsp_vmem_write,
   input wire logic [8:0]  rsp_dot_now,
   input wire logic [8:0]  rsp_line_now
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_vmem_address) && $stable(rsp_dot_now))
   `ASSERT_IMPLIES(a_one_strobe, clock, reset, rsp_valid, !(rsp_vmem_read && rsp_vmem_write))
   `ASSERT_IMPLIES(a_addr_idle, clock, reset, rsp_valid && !rsp_vmem_read && !rsp_vmem_write, rsp_vmem_address == 16'd0)
   `ASSERT_IMPLIES(a_vmem_no_byte, clock, reset, rsp_valid && (rsp_vmem_read || rsp_vmem_write), rsp_read_byte == 8'd0)
   `ASSERT_IMPLIES(a_count_range, clock, reset, rsp_valid, (rsp_dot_now <= 9'(LAST_DOT)) && (rsp_line_now <= 9'(LAST_LINE)))

endmodule

bind video_scroll_address_registers vsar_checker u_vsar_checker (.*);

`default_nettype wire

@@ tb/sv/tb_video_scroll_address_registers.sv @@
`timescale 1ns / 1ps
// Testbench for video_scroll_address_registers: directed and random CPU accesses and dot
// ticks, checked against an in-bench model of the timing and scroll address registers.
// Depends on vsar_pkg and the video_scroll_address_registers RTL.

module tb_video_scroll_address_registers;
   import vsar_pkg::*;

   localparam int unsigned RANDOM_ITEMS   = 1800;
   localparam int unsigned SKIP_SPACING   = 60;
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned DRAIN_CYCLES   = 20;
   localparam int unsigned MAX_REPORTS    = 10;
   localparam logic [3:0]  REQ_CODE_TOP   = 4'hF;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] val;
      logic       peek;
      logic       bulk;
   } bus_item_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [3:0]  req_type = REQ_TICK;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_peek = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_byte;
   logic        rsp_nmi_out;
   logic [15:0] rsp_vmem_address;
   logic        rsp_vmem_read;
   logic        rsp_vmem_write;
   logic [8:0]  rsp_dot_now;
   logic [8:0]  rsp_line_now;

   video_scroll_address_registers uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_data_byte    (req_data_byte),
      .req_peek         (req_peek),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_byte    (rsp_read_byte),
      .rsp_nmi_out      (rsp_nmi_out),
      .rsp_vmem_address (rsp_vmem_address),
      .rsp_vmem_read    (rsp_vmem_read),
      .rsp_vmem_write   (rsp_vmem_write),
      .rsp_dot_now      (rsp_dot_now),
      .rsp_line_now     (rsp_line_now)
   );

   // model state
   logic [8:0]  dot_ct, line_ct;
   logic [15:0] cur_v, tmp_t;
   logic [2:0]  fine_x;
   logic        w_latch, vbl;
   logic [7:0]  ctrl_reg, mask_reg, oam_ptr;
   logic [7:0]  oam_mem [SPRITE_TABLE_DEPTH];

   bus_item_type stim_q[$];
   rsp_type     rsp_want_q[$];
   logic [8:0]  gen_dot = 9'd0;
   logic [8:0]  gen_line = 9'd0;
   int unsigned item_count = 0;
   int unsigned total_items = 0;
   int unsigned reqs_taken = 0;
   int unsigned results_seen = 0;
   int unsigned err_count = 0;
   int unsigned gap_left = 0;
   int unsigned hold_left = 0;
   int unsigned next_hold_at = 150;
   int unsigned stuck_cycles = 0;
   logic        req_took = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void step_position(inout logic [8:0] d, inout logic [8:0] l);
      if (d == LAST_DOT) begin
         d = 9'd0;
         l = (l == LAST_LINE) ? 9'd0 : l + 9'd1;
      end else begin
         d = d + 9'd1;
      end
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(999, 0);
      if (r < 800) return 0;
      if (r < 990) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic rsp_type apply_access(input bus_item_type it);
      logic [8:0]  d;
      logic [4:0]  cy;
      logic [15:0] stride;
      rsp_type     r;
      r = '0;
      d = dot_ct;
      stride = ctrl_reg[2] ? 16'd32 : 16'd1;
      case (it.kind)
         REQ_TICK: begin
            if (d != 9'd0) begin
               if (line_ct >= POST_LINE && line_ct < LAST_LINE) begin
                  if (d == 9'd1 && line_ct == VBLANK_LINE) vbl = 1'b1;
               end else begin
                  if (d == 9'd1 && line_ct == LAST_LINE) vbl = 1'b0;
                  if (mask_reg[3]) begin
                     if ((d < 256 || d > 320) && d[2:0] == 3'd0) begin
                        if (cur_v[4:0] == 5'd31) cur_v = {cur_v[15:5], 5'd0} ^ NT_H_BIT;
                        else cur_v = cur_v + 16'd1;
                     end
                     if (d == 9'd256) begin
                        if (cur_v[14:12] != 3'd7) begin
                           cur_v = cur_v + FINE_Y_ONE;
                        end else begin
                           cur_v[14:12] = 3'd0;
                           cy = cur_v[9:5];
                           if (cy == COARSE_Y_WRAP) begin
                              cy = 5'd0;
                              cur_v = cur_v ^ NT_V_BIT;
                           end else if (cy == COARSE_Y_LAST) begin
                              cy = 5'd0;
                           end else begin
                              cy = cy + 5'd1;
                           end
                           cur_v[9:5] = cy;
                        end
                     end else if (d == 9'd257) begin
                        cur_v = (cur_v & ~HORIZ_MASK) | (tmp_t & HORIZ_MASK);
                     end else if (line_ct == LAST_LINE && d >= 280 && d <= 304) begin
                        cur_v = (cur_v & HORIZ_MASK) | (tmp_t & ~HORIZ_MASK);
                     end
                  end
               end
            end
            step_position(dot_ct, line_ct);
         end
         REQ_CTRL_WR: begin
            ctrl_reg = it.val;
            tmp_t = (tmp_t & CTRL_NT_KEEP) | {4'd0, it.val[1:0], 10'd0};
         end
         REQ_MASK_WR: mask_reg = it.val;
         REQ_STAT_RD: begin
            r.read_byte = {vbl, 7'd0};
            if (!it.peek) begin
               vbl = 1'b0;
               w_latch = 1'b0;
            end
         end
         REQ_OAMA_WR: oam_ptr = it.val;
         REQ_OAMD_WR: begin
            oam_mem[oam_ptr] = it.val;
            oam_ptr = oam_ptr + 8'd1;
         end
         REQ_OAMD_RD: r.read_byte = oam_mem[oam_ptr];
         REQ_SCROL_WR: begin
            if (!w_latch) begin
               tmp_t = {tmp_t[15:5], it.val[7:3]};
               fine_x = it.val[2:0];
            end else begin
               tmp_t = (tmp_t & SCROLL_KEEP) | {1'b0, it.val[2:0], 2'b00, it.val[7:3], 5'd0};
            end
            w_latch = ~w_latch;
         end
         REQ_ADDR_WR: begin
            if (!w_latch) begin
               tmp_t = {2'b00, it.val[5:0], tmp_t[7:0]};
            end else begin
               tmp_t = {tmp_t[15:8], it.val};
               cur_v = tmp_t;
            end
            w_latch = ~w_latch;
         end
         REQ_DATA_WR: begin
            r.vmem_address = cur_v;
            r.vmem_write = 1'b1;
            cur_v = cur_v + stride;
         end
         REQ_DATA_RD: begin
            r.vmem_address = cur_v;
            r.vmem_read = 1'b1;
            if (!it.peek) cur_v = cur_v + stride;
         end
         default: ;
      endcase
      r.nmi_out = ctrl_reg[7] & vbl;
      r.dot_now = dot_ct;
      r.line_now = line_ct;
      return r;
   endfunction

   task automatic push_access(input logic [3:0] k, input logic [7:0] v, input logic p,
                              input logic bk);
      stim_q.push_back('{kind: k, val: v, peek: p, bulk: bk});
      if (k == REQ_TICK) step_position(gen_dot, gen_line);
      item_count++;
   endtask

   task automatic run_ticks_to(input logic [8:0] l, input logic [8:0] d);
      while (gen_dot != d || gen_line != l)
         push_access(REQ_TICK, 8'($urandom), 1'($urandom), 1'b1);
   endtask

   // driver
   always @(negedge clock) begin : driver
      bus_item_type nxt;
      if (!reset && (!req_valid || req_took)) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (stim_q.size() != 0) begin
            nxt = stim_q.pop_front();
            req_type <= nxt.kind;
            req_data_byte <= nxt.val;
            req_peek <= nxt.peek;
            req_valid <= 1'b1;
            gap_left <= nxt.bulk ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stalls, with a long hold-off now and then to back up the input
   always @(negedge clock) begin : receiver
      int unsigned g;
      if (!reset) begin
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (results_seen >= next_hold_at) begin
            hold_left <= HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
            next_hold_at <= next_hold_at + 6000;
         end else begin
            g = pick_gap();
            rsp_ready <= (g == 0);
            hold_left <= (g == 0) ? 0 : g - 1;
         end
      end
   end

   // monitor and model update
   always @(posedge clock) begin : monitor
      rsp_type got;
      rsp_type want;
      if (reset) begin
         dot_ct = 9'd0;
         line_ct = 9'd0;
         cur_v = 16'd0;
         tmp_t = 16'd0;
         fine_x = 3'd0;
         w_latch = 1'b0;
         vbl = 1'b0;
         ctrl_reg = 8'd0;
         mask_reg = 8'd0;
         oam_ptr = 8'd0;
         for (int i = 0; i < SPRITE_TABLE_DEPTH; i++) oam_mem[i] = 8'd0;
         req_took <= 1'b0;
      end else begin
         req_took <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            got.read_byte = rsp_read_byte;
            got.nmi_out = rsp_nmi_out;
            got.vmem_address = rsp_vmem_address;
            got.vmem_read = rsp_vmem_read;
            got.vmem_write = rsp_vmem_write;
            got.dot_now = rsp_dot_now;
            got.line_now = rsp_line_now;
            if (rsp_want_q.size() == 0) begin
               err_count <= err_count + 1;
               if (err_count < MAX_REPORTS)
                  $display("unexpected transaction: rd=%h dot=%0d line=%0d",
                           got.read_byte, got.dot_now, got.line_now);
            end else begin
               want = rsp_want_q.pop_front();
               if (got.read_byte !== want.read_byte || got.nmi_out !== want.nmi_out ||
                   got.vmem_address !== want.vmem_address ||
                   got.vmem_read !== want.vmem_read || got.vmem_write !== want.vmem_write ||
                   got.dot_now !== want.dot_now || got.line_now !== want.line_now) begin
                  err_count <= err_count + 1;
                  if (err_count < MAX_REPORTS) begin
                     $display("mismatch: want rd=%h nmi=%b va=%h r=%b w=%b dot=%0d line=%0d",
                              want.read_byte, want.nmi_out, want.vmem_address, want.vmem_read,
                              want.vmem_write, want.dot_now, want.line_now);
                     $display("          got  rd=%h nmi=%b va=%h r=%b w=%b dot=%0d line=%0d",
                              got.read_byte, got.nmi_out, got.vmem_address, got.vmem_read,
                              got.vmem_write, got.dot_now, got.line_now);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            rsp_want_q.push_back(apply_access('{kind: req_type, val: req_data_byte,
                                                peek: req_peek, bulk: 1'b0}));
            reqs_taken <= reqs_taken + 1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned pick, n, base, next_skip;
      logic [7:0]  b;
      logic [8:0]  td, tl;
      // directed: reads after clear, pointer wrap, strides, peeks, latch, unknown codes
      push_access(REQ_STAT_RD, 8'h00, 1'b1, 1'b0);
      push_access(REQ_STAT_RD, 8'hFF, 1'b0, 1'b0);
      push_access(REQ_OAMD_RD, 8'h00, 1'b1, 1'b0);
      push_access(REQ_OAMA_WR, 8'hFF, 1'b0, 1'b0);
      push_access(REQ_OAMD_WR, 8'hA5, 1'b1, 1'b0);
      push_access(REQ_OAMD_RD, 8'h00, 1'b0, 1'b0);
      push_access(REQ_OAMA_WR, 8'hFF, 1'b0, 1'b0);
      push_access(REQ_OAMD_RD, 8'hFF, 1'b0, 1'b0);
      push_access(REQ_CTRL_WR, 8'h84, 1'b0, 1'b0);
      push_access(REQ_ADDR_WR, 8'hFF, 1'b0, 1'b0);
      push_access(REQ_ADDR_WR, 8'hFF, 1'b1, 1'b0);
      push_access(REQ_DATA_WR, 8'h5A, 1'b1, 1'b0);
      push_access(REQ_DATA_RD, 8'h00, 1'b1, 1'b0);
      push_access(REQ_DATA_RD, 8'h00, 1'b0, 1'b0);
      push_access(REQ_CTRL_WR, 8'h03, 1'b0, 1'b0);
      push_access(REQ_SCROL_WR, 8'hFF, 1'b1, 1'b0);
      push_access(REQ_SCROL_WR, 8'h00, 1'b0, 1'b0);
      push_access(REQ_ADDR_WR, 8'h00, 1'b0, 1'b0);
      push_access(REQ_ADDR_WR, 8'h00, 1'b0, 1'b0);
      push_access(REQ_MASK_WR, 8'hFF, 1'b0, 1'b0);
      push_access(REQ_TICK, 8'hFF, 1'b1, 1'b0);
      push_access(REQ_TICK, 8'h00, 1'b0, 1'b0);
      push_access(REQ_MASK_WR, 8'h00, 1'b0, 1'b0);
      push_access(REQ_CODE_TOP, 8'hFF, 1'b1, 1'b0);
      push_access(REQ_DATA_RD + 4'd1, 8'h00, 1'b0, 1'b0);

      base = item_count;
      next_skip = base + SKIP_SPACING;
      while (item_count < base + RANDOM_ITEMS) begin
         // jump the raster to just before the end-of-line scroll updates
         if (item_count >= next_skip) begin
            b = 8'($urandom);
            if ($urandom_range(3, 0) != 0) b[3] = 1'b1;
            push_access(REQ_MASK_WR, b, 1'($urandom), 1'b0);
            td = 9'($urandom_range(255, 246));
            tl = (gen_dot < td) ? gen_line :
                 ((gen_line == LAST_LINE) ? 9'd0 : gen_line + 9'd1);
            run_ticks_to(tl, td);
            next_skip = item_count + SKIP_SPACING;
         end
         pick = $urandom_range(99, 0);
         if (pick < 40) begin
            n = $urandom_range(12, 1);
            repeat (n) push_access(REQ_TICK, 8'($urandom), 1'($urandom), 1'b0);
         end else if (pick < 52) begin
            if ($urandom_range(3, 0) != 0) push_access(REQ_STAT_RD, 8'($urandom), 1'b0, 1'b0);
            push_access(REQ_ADDR_WR, 8'($urandom), 1'($urandom), 1'b0);
            push_access(REQ_ADDR_WR, 8'($urandom), 1'($urandom), 1'b0);
            n = $urandom_range(4, 1);
            repeat (n)
               push_access($urandom_range(1, 0) ? REQ_DATA_WR : REQ_DATA_RD,
                           8'($urandom), 1'($urandom), 1'b0);
         end else if (pick < 60) begin
            if ($urandom_range(3, 0) != 0) push_access(REQ_STAT_RD, 8'($urandom), 1'b0, 1'b0);
            push_access(REQ_SCROL_WR, 8'($urandom), 1'($urandom), 1'b0);
            push_access(REQ_SCROL_WR, 8'($urandom), 1'($urandom), 1'b0);
         end else if (pick < 68) begin
            b = 8'($urandom);
            if ($urandom_range(3, 0) == 0) b[7:2] = 6'h3F;
            push_access(REQ_OAMA_WR, b, 1'($urandom), 1'b0);
            n = $urandom_range(3, 1);
            repeat (n) push_access(REQ_OAMD_WR, 8'($urandom), 1'($urandom), 1'b0);
            push_access(REQ_OAMA_WR, b, 1'($urandom), 1'b0);
            push_access(REQ_OAMD_RD, 8'($urandom), 1'($urandom), 1'b0);
         end else if (pick < 74) begin
            push_access(REQ_CTRL_WR, 8'($urandom), 1'($urandom), 1'b0);
         end else if (pick < 80) begin
            b = 8'($urandom);
            if ($urandom_range(3, 0) != 0) b[3] = 1'b1;
            push_access(REQ_MASK_WR, b, 1'($urandom), 1'b0);
         end else if (pick < 88) begin
            push_access(REQ_STAT_RD, 8'($urandom), 1'($urandom), 1'b0);
         end else begin
            push_access(4'($urandom_range(REQ_CODE_TOP, REQ_TICK)), 8'($urandom),
                        1'($urandom), 1'b0);
         end
      end
      total_items = stim_q.size();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (reqs_taken != total_items) @(negedge clock);
      while (rsp_want_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/vsar_pkg.sv
rtl/vsar_oam.sv
rtl/vsar_core.sv
rtl/video_scroll_address_registers.sv
rtl/vsar_checker.sv
tb/sv/tb_video_scroll_address_registers.sv
